// ===== design/hsr_pkg.sv =====
// Shared constants, register map and lane result type for haze scene radiance recovery.
package hsr_pkg;

    localparam int FRAC_BITS_DEF = 15;
    localparam int PIX_W         = 8;
    localparam int TRANS_W       = 16;
    localparam int LANES         = 3;
    localparam int QUO_W         = PIX_W;
    // front stage, overflow step, one step per quotient bit
    localparam int LANE_STAGES   = QUO_W + 2;

    localparam int CFG_AW        = 5;
    localparam int CFG_DW        = 32;
    localparam int REG_IDX_W     = 3;

    localparam logic [REG_IDX_W-1:0] REG_AIRLIGHT_B  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AIRLIGHT_G  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_AIRLIGHT_R  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TRANS_FLOOR = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_LEVEL   = 3'd4;

    localparam logic [PIX_W-1:0]   AIRLIGHT_RST    = 8'd255;
    localparam logic [TRANS_W-1:0] TRANS_FLOOR_RST = 16'd3277;
    localparam logic [PIX_W-1:0]   MAX_LEVEL_RST   = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [QUO_W-1:0] quo;
        logic             big;
        logic             neg;
    } lane_res_t;

endpackage

// ===== design/hsr_lane.sv =====
// One color channel: transmission floor, numerator build and pipelined restoring divider.
module hsr_lane #(
    parameter int FRAC_BITS = hsr_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic [hsr_pkg::LANE_STAGES-1:0] adv,
    input  logic [hsr_pkg::PIX_W-1:0]       hazy,
    input  logic [hsr_pkg::TRANS_W-1:0]     trans,
    input  logic [hsr_pkg::PIX_W-1:0]       airlight,
    input  logic [hsr_pkg::TRANS_W-1:0]     trans_floor,
    output hsr_pkg::lane_res_t              res
);

    localparam int PW     = hsr_pkg::PIX_W;
    localparam int TW     = hsr_pkg::TRANS_W;
    localparam int QW     = hsr_pkg::QUO_W;
    localparam int NST    = hsr_pkg::LANE_STAGES;
    localparam int SHIFTW = FRAC_BITS + PW;
    localparam int PRODW  = PW + TW;
    localparam int NUM_W  = ((SHIFTW > PRODW) ? SHIFTW : PRODW) + 1;

    logic [TW-1:0]          t_eff;
    logic signed [PW:0]     diff;
    logic signed [NUM_W:0]  diff_s;
    logic [PRODW-1:0]       prod;
    logic signed [NUM_W:0]  num_s;

    logic [NUM_W-1:0] rem_reg  [NST];
    logic [TW-1:0]    t_reg    [NST];
    logic [PW-1:0]    pix_reg  [NST];
    logic [QW-1:0]    quo_reg  [NST];
    logic             big_reg  [NST];
    logic             neg_reg  [NST];

    always_comb begin
        t_eff = (trans < trans_floor) ? trans_floor : trans;
        if (t_eff == '0) begin
            t_eff = TW'(1);
        end
        diff   = $signed({1'b0, hazy}) - $signed({1'b0, airlight});
        diff_s = (NUM_W + 1)'(diff) <<< FRAC_BITS;
        prod   = airlight * t_eff;
        num_s  = diff_s + $signed((NUM_W + 1)'(prod));
    end

    // negative numerator always ends as 0, so only its magnitude sign is kept
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            rem_reg[0] <= num_s[NUM_W-1:0];
            neg_reg[0] <= num_s[NUM_W];
            t_reg[0]   <= t_eff;
            pix_reg[0] <= hazy;
            quo_reg[0] <= '0;
            big_reg[0] <= 1'b0;
        end
    end

    for (genvar s = 1; s < NST; s++) begin : g_step
        localparam int K = NST - 1 - s;
        logic [NUM_W-1:0] sub;
        logic             ge;

        assign sub = NUM_W'(t_reg[s-1]) << K;
        assign ge  = rem_reg[s-1] >= sub;

        if (K == QW) begin : g_ovf
            // quotient at least 2^QW: always above max_level
            always_ff @(posedge aclk) begin
                if (adv[s]) begin
                    rem_reg[s] <= rem_reg[s-1];
                    big_reg[s] <= ge;
                    quo_reg[s] <= quo_reg[s-1];
                    t_reg[s]   <= t_reg[s-1];
                    pix_reg[s] <= pix_reg[s-1];
                    neg_reg[s] <= neg_reg[s-1];
                end
            end
        end else begin : g_bit
            always_ff @(posedge aclk) begin
                if (adv[s]) begin
                    rem_reg[s] <= ge ? (rem_reg[s-1] - sub) : rem_reg[s-1];
                    big_reg[s] <= big_reg[s-1];
                    quo_reg[s] <= quo_reg[s-1] | (QW'(ge) << K);
                    t_reg[s]   <= t_reg[s-1];
                    pix_reg[s] <= pix_reg[s-1];
                    neg_reg[s] <= neg_reg[s-1];
                end
            end
        end
    end

    assign res.pix = pix_reg[NST-1];
    assign res.quo = quo_reg[NST-1];
    assign res.big = big_reg[NST-1];
    assign res.neg = neg_reg[NST-1];

endmodule

// ===== design/hsr_out.sv =====
// Merge stage: per-lane clamp and fallback, packed into the output data register.
module hsr_out (
    input  logic                                aclk,
    input  logic                                load,
    input  hsr_pkg::lane_res_t                  lane_res [hsr_pkg::LANES],
    input  logic [hsr_pkg::PIX_W-1:0]           max_level,
    output logic [hsr_pkg::LANES*hsr_pkg::PIX_W-1:0] tdata
);

    localparam int PW = hsr_pkg::PIX_W;
    localparam int NL = hsr_pkg::LANES;

    logic [NL*PW-1:0] tdata_reg;
    logic [NL*PW-1:0] tdata_next;

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            priority if (lane_res[i].neg) begin
                tdata_next[i*PW +: PW] = '0;
            end else if (lane_res[i].big || (lane_res[i].quo > max_level)) begin
                tdata_next[i*PW +: PW] = lane_res[i].pix;
            end else begin
                tdata_next[i*PW +: PW] = lane_res[i].quo;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tdata_reg <= tdata_next;
        end
    end

    assign tdata = tdata_reg;

endmodule

// ===== design/haze_scene_radiance_recovery.sv =====
// Top level: configuration registers, stage handshake control, lanes and merge stage.
//
// Recovers scene radiance of one pixel per transaction: J = (I - A) / t + A for
// blue, green and red, with t raised to trans_floor, results above max_level
// replaced by the hazy byte and negative results clamped to 0.
// Input channel s_*: s_tdata carries hazy_b, hazy_g, hazy_r (8 bits each) and
// trans_b, trans_g, trans_r (16 bits each, Q.FRAC_BITS).
// Output channel m_*: m_tdata carries clear_b, clear_g, clear_r.
// Each channel runs in its own lane: one front stage (floor, numerator multiply),
// one overflow compare stage and eight compare-subtract stages of a restoring
// divider, one quotient bit each, followed by a merge register feeding m_tdata.
// Throughput: one pixel per cycle while m_tready does not stall the stages,
// set by the one-step-per-stage divider.
// When m_tready is low, the merge register holds its transaction and the lane
// stages keep accepting until every stage is occupied; s_tready then drops.
// Synchronous reset empties all stages and loads the register defaults
// (airlight 255, trans_floor 3277, max_level 255).
// APB registers at 0x00..0x10: airlight_b, airlight_g, airlight_r, trans_floor,
// max_level. Write them only while the block is empty.
module haze_scene_radiance_recovery #(
    parameter int FRAC_BITS = hsr_pkg::FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // hazy_b, hazy_g, hazy_r, trans_b, trans_g, trans_r from bit 0 up
    input  logic [71:0]                s_tdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // clear_b, clear_g, clear_r from bit 0 up
    output logic [23:0]                m_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hsr_pkg::CFG_AW-1:0] paddr,
    input  logic [hsr_pkg::CFG_DW-1:0] pwdata,
    output logic [hsr_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);

    localparam int PW  = hsr_pkg::PIX_W;
    localparam int TW  = hsr_pkg::TRANS_W;
    localparam int NL  = hsr_pkg::LANES;
    localparam int NST = hsr_pkg::LANE_STAGES;

    logic [PW-1:0] air_b_reg, air_g_reg, air_r_reg, max_level_reg;
    logic [TW-1:0] floor_reg;
    logic [hsr_pkg::REG_IDX_W-1:0] reg_idx;
    logic cfg_wr;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST:0]   rdy;
    logic           m_tvalid_reg;
    logic           m_tvalid_next;

    logic [PW-1:0]      air   [NL];
    hsr_pkg::lane_res_t lres  [NL];

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[hsr_pkg::CFG_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            air_b_reg     <= hsr_pkg::AIRLIGHT_RST;
            air_g_reg     <= hsr_pkg::AIRLIGHT_RST;
            air_r_reg     <= hsr_pkg::AIRLIGHT_RST;
            floor_reg     <= hsr_pkg::TRANS_FLOOR_RST;
            max_level_reg <= hsr_pkg::MAX_LEVEL_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                hsr_pkg::REG_AIRLIGHT_B:  air_b_reg     <= pwdata[PW-1:0];
                hsr_pkg::REG_AIRLIGHT_G:  air_g_reg     <= pwdata[PW-1:0];
                hsr_pkg::REG_AIRLIGHT_R:  air_r_reg     <= pwdata[PW-1:0];
                hsr_pkg::REG_TRANS_FLOOR: floor_reg     <= pwdata[TW-1:0];
                hsr_pkg::REG_MAX_LEVEL:   max_level_reg <= pwdata[PW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            hsr_pkg::REG_AIRLIGHT_B:  prdata = hsr_pkg::CFG_DW'(air_b_reg);
            hsr_pkg::REG_AIRLIGHT_G:  prdata = hsr_pkg::CFG_DW'(air_g_reg);
            hsr_pkg::REG_AIRLIGHT_R:  prdata = hsr_pkg::CFG_DW'(air_r_reg);
            hsr_pkg::REG_TRANS_FLOOR: prdata = hsr_pkg::CFG_DW'(floor_reg);
            hsr_pkg::REG_MAX_LEVEL:   prdata = hsr_pkg::CFG_DW'(max_level_reg);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- stage handshake ----------------
    // a stage loads when it is empty or its contents move on
    always_comb begin
        rdy[NST] = !m_tvalid_reg || m_tready;
        for (int s = NST - 1; s >= 0; s--) begin
            rdy[s] = !vld_reg[s] || rdy[s+1];
        end
        for (int s = 0; s < NST; s++) begin
            if (rdy[s]) begin
                vld_next[s] = (s == 0) ? s_tvalid : vld_reg[(s == 0) ? 0 : s - 1];
            end else begin
                vld_next[s] = vld_reg[s];
            end
        end
        m_tvalid_next = rdy[NST] ? vld_reg[NST-1] : m_tvalid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            vld_reg      <= vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = m_tvalid_reg;

    // ---------------- lanes ----------------
    assign air[0] = air_b_reg;
    assign air[1] = air_g_reg;
    assign air[2] = air_r_reg;

    for (genvar i = 0; i < NL; i++) begin : g_lane
        hsr_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk        (aclk),
            .adv         (rdy[NST-1:0]),
            .hazy        (s_tdata[i*PW +: PW]),
            .trans       (s_tdata[NL*PW + i*TW +: TW]),
            .airlight    (air[i]),
            .trans_floor (floor_reg),
            .res         (lres[i])
        );
    end

    hsr_out u_out (
        .aclk      (aclk),
        .load      (rdy[NST]),
        .lane_res  (lres),
        .max_level (max_level_reg),
        .tdata     (m_tdata)
    );

    // ---------------- assertions ----------------
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (vld_reg == '0 && !m_tvalid_reg))
        else $error("pipeline not empty after reset");

    a_last_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NST-1] && rdy[NST]) |=> m_tvalid_reg)
        else $error("finished lane result not taken into output register");

    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ($countones({vld_reg, m_tvalid_reg}) ==
                  $past($countones({vld_reg, m_tvalid_reg}))
                  + $past(s_tvalid && s_tready) - $past(m_tvalid && m_tready)))
        else $error("transaction lost or duplicated in the stages");

endmodule

// ===== bench/hsr_checker.sv =====
`timescale 1ns / 1ps
// Checker for haze scene radiance recovery: tracks registers, predicts pixels, compares results.
module hsr_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    // hazy_b, hazy_g, hazy_r, trans_b, trans_g, trans_r from bit 0 up
    input  logic [71:0]                        s_tdata,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    // clear_b, clear_g, clear_r from bit 0 up
    input  logic [23:0]                        m_tdata,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hsr_pkg::CFG_AW-1:0]         paddr,
    input  logic [hsr_pkg::CFG_DW-1:0]         pwdata,
    input  logic [hsr_pkg::CFG_DW-1:0]         prdata,
    input  logic                               pready,
    output int                                 fail_count,
    output int                                 pending
);

    localparam int EXP_DEPTH = 64;

    typedef struct packed {
        logic [hsr_pkg::TRANS_W-1:0] trans_r;
        logic [hsr_pkg::TRANS_W-1:0] trans_g;
        logic [hsr_pkg::TRANS_W-1:0] trans_b;
        logic [hsr_pkg::PIX_W-1:0]   hazy_r;
        logic [hsr_pkg::PIX_W-1:0]   hazy_g;
        logic [hsr_pkg::PIX_W-1:0]   hazy_b;
    } hazy_pixel_t;

    typedef struct packed {
        logic [hsr_pkg::PIX_W-1:0] clear_r;
        logic [hsr_pkg::PIX_W-1:0] clear_g;
        logic [hsr_pkg::PIX_W-1:0] clear_b;
    } clear_pixel_t;

    logic [hsr_pkg::PIX_W-1:0]   air_b;
    logic [hsr_pkg::PIX_W-1:0]   air_g;
    logic [hsr_pkg::PIX_W-1:0]   air_r;
    logic [hsr_pkg::TRANS_W-1:0] floor_t;
    logic [hsr_pkg::PIX_W-1:0]   lvl_max;

    // expected pixels in arrival order
    clear_pixel_t exp_mem [EXP_DEPTH];
    int           exp_wr;
    int           exp_rd;

    initial begin
        fail_count = 0;
        pending    = 0;
        exp_wr     = 0;
        exp_rd     = 0;
    end

    function automatic logic [hsr_pkg::PIX_W-1:0] recover_lane(
        logic [hsr_pkg::PIX_W-1:0] hazy, logic [hsr_pkg::TRANS_W-1:0] trans,
        logic [hsr_pkg::PIX_W-1:0] air);
        longint pix_v;
        longint air_v;
        longint max_v;
        longint t_used;
        longint num;
        longint quo;
        pix_v  = longint'(hazy);
        air_v  = longint'(air);
        max_v  = longint'(lvl_max);
        t_used = longint'(trans);
        if (t_used < longint'(floor_t))
            t_used = longint'(floor_t);
        // zero floor with zero transmission: use the smallest step
        if (t_used == 0)
            t_used = 1;
        num = (pix_v - air_v) * (longint'(1) << hsr_pkg::FRAC_BITS_DEF) + air_v * t_used;
        quo = num / t_used;
        if (quo > max_v)
            return hazy;
        if (quo < 0)
            return '0;
        return quo[hsr_pkg::PIX_W-1:0];
    endfunction

    function automatic clear_pixel_t recover_pixel(hazy_pixel_t px);
        clear_pixel_t res;
        res.clear_b = recover_lane(px.hazy_b, px.trans_b, air_b);
        res.clear_g = recover_lane(px.hazy_g, px.trans_g, air_g);
        res.clear_r = recover_lane(px.hazy_r, px.trans_r, air_r);
        return res;
    endfunction

    function automatic logic [hsr_pkg::CFG_DW-1:0] reg_value(
        logic [hsr_pkg::REG_IDX_W-1:0] idx);
        unique case (idx)
            hsr_pkg::REG_AIRLIGHT_B:  return hsr_pkg::CFG_DW'(air_b);
            hsr_pkg::REG_AIRLIGHT_G:  return hsr_pkg::CFG_DW'(air_g);
            hsr_pkg::REG_AIRLIGHT_R:  return hsr_pkg::CFG_DW'(air_r);
            hsr_pkg::REG_TRANS_FLOOR: return hsr_pkg::CFG_DW'(floor_t);
            hsr_pkg::REG_MAX_LEVEL:   return hsr_pkg::CFG_DW'(lvl_max);
            default:                  return '0;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [hsr_pkg::CFG_DW-1:0] got,
                                   logic [hsr_pkg::CFG_DW-1:0] want);
        $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic put_expected(clear_pixel_t px);
        exp_mem[exp_wr % EXP_DEPTH] = px;
        exp_wr++;
    endtask

    always @(posedge aclk) begin
        logic [hsr_pkg::REG_IDX_W-1:0] idx;
        clear_pixel_t                  got;
        clear_pixel_t                  want;
        idx = paddr[hsr_pkg::CFG_AW-1:2];
        if (!aresetn) begin
            air_b   = hsr_pkg::AIRLIGHT_RST;
            air_g   = hsr_pkg::AIRLIGHT_RST;
            air_r   = hsr_pkg::AIRLIGHT_RST;
            floor_t = hsr_pkg::TRANS_FLOOR_RST;
            lvl_max = hsr_pkg::MAX_LEVEL_RST;
            exp_wr  = 0;
            exp_rd  = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                // indexes past the last register are ignored
                unique case (idx)
                    hsr_pkg::REG_AIRLIGHT_B:  air_b   = pwdata[hsr_pkg::PIX_W-1:0];
                    hsr_pkg::REG_AIRLIGHT_G:  air_g   = pwdata[hsr_pkg::PIX_W-1:0];
                    hsr_pkg::REG_AIRLIGHT_R:  air_r   = pwdata[hsr_pkg::PIX_W-1:0];
                    hsr_pkg::REG_TRANS_FLOOR: floor_t = pwdata[hsr_pkg::TRANS_W-1:0];
                    hsr_pkg::REG_MAX_LEVEL:   lvl_max = pwdata[hsr_pkg::PIX_W-1:0];
                    default: ;
                endcase
            end
            if (psel && penable && !pwrite && pready && idx <= hsr_pkg::REG_MAX_LEVEL) begin
                if (prdata !== reg_value(idx))
                    report_mismatch($sformatf("register %0d readback", idx), prdata,
                                    reg_value(idx));
            end
            if (s_tvalid && s_tready)
                put_expected(recover_pixel(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (exp_wr == exp_rd) begin
                    report_mismatch("result transaction with nothing expected",
                                    hsr_pkg::CFG_DW'(got), '0);
                end else begin
                    want = exp_mem[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (got.clear_b !== want.clear_b)
                        report_mismatch("clear_b", hsr_pkg::CFG_DW'(got.clear_b),
                                        hsr_pkg::CFG_DW'(want.clear_b));
                    if (got.clear_g !== want.clear_g)
                        report_mismatch("clear_g", hsr_pkg::CFG_DW'(got.clear_g),
                                        hsr_pkg::CFG_DW'(want.clear_g));
                    if (got.clear_r !== want.clear_r)
                        report_mismatch("clear_r", hsr_pkg::CFG_DW'(got.clear_r),
                                        hsr_pkg::CFG_DW'(want.clear_r));
                end
            end
        end
        pending <= exp_wr - exp_rd;
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for haze scene radiance recovery: clock, reset, stimulus, registers, verdict.
module tb_top;

    localparam int CYCLE_LIMIT       = 200000;
    localparam int SETTLE_CYCLES     = 16;
    localparam int ITEMS_PER_SETTING = 175;
    localparam int SETTINGS_PER_RUN  = 8;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic [71:0]                   s_tdata  = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [23:0]                   m_tdata;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [hsr_pkg::CFG_AW-1:0]    paddr    = '0;
    logic [hsr_pkg::CFG_DW-1:0]    pwdata   = '0;
    logic [hsr_pkg::CFG_DW-1:0]    prdata;
    logic                          pready;

    int                            fail_count;
    int                            pending;
    int                            src_idle_pct   = 0;
    int                            sink_stall_pct = 0;
    logic [hsr_pkg::TRANS_W-1:0]   cur_floor      = hsr_pkg::TRANS_FLOOR_RST;

    int src_idle_by_phase[4]   = '{0, 64, 0, 15};
    int sink_stall_by_phase[4] = '{0, 0, 64, 15};

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    haze_scene_radiance_recovery dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    hsr_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // random backpressure on the result channel
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic logic [71:0] pack_pixel(logic [7:0] h_b, logic [7:0] h_g,
                                               logic [7:0] h_r, logic [15:0] t_b,
                                               logic [15:0] t_g, logic [15:0] t_r);
        return {t_r, t_g, t_b, h_r, h_g, h_b};
    endfunction

    function automatic logic [hsr_pkg::PIX_W-1:0] rand_hazy();
        unique case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return hsr_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [hsr_pkg::TRANS_W-1:0] rand_trans();
        unique case ($urandom_range(0, 9))
            0:       return '0;
            1:       return hsr_pkg::TRANS_W'(32768);
            2:       return hsr_pkg::TRANS_W'($urandom_range(0, 65535));
            // straddle the floor
            3:       return cur_floor + hsr_pkg::TRANS_W'($urandom_range(0, 4))
                            - hsr_pkg::TRANS_W'(2);
            default: return hsr_pkg::TRANS_W'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic send_pixel(logic [71:0] px);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off the sender until every expected pixel has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [hsr_pkg::REG_IDX_W-1:0] idx,
                             logic [hsr_pkg::CFG_DW-1:0] val, int width);
        logic [hsr_pkg::CFG_DW-1:0] junk;
        junk    = $urandom() << width;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val | junk;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic cfg_read(logic [hsr_pkg::REG_IDX_W-1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_regs(logic [7:0] a_b, logic [7:0] a_g, logic [7:0] a_r,
                             logic [15:0] flr, logic [7:0] lvl);
        cfg_write(hsr_pkg::REG_AIRLIGHT_B, hsr_pkg::CFG_DW'(a_b), hsr_pkg::PIX_W);
        cfg_write(hsr_pkg::REG_AIRLIGHT_G, hsr_pkg::CFG_DW'(a_g), hsr_pkg::PIX_W);
        cfg_write(hsr_pkg::REG_AIRLIGHT_R, hsr_pkg::CFG_DW'(a_r), hsr_pkg::PIX_W);
        cfg_write(hsr_pkg::REG_TRANS_FLOOR, hsr_pkg::CFG_DW'(flr), hsr_pkg::TRANS_W);
        cfg_write(hsr_pkg::REG_MAX_LEVEL, hsr_pkg::CFG_DW'(lvl), hsr_pkg::PIX_W);
        cur_floor = flr;
        for (int i = 0; i <= int'(hsr_pkg::REG_MAX_LEVEL); i++)
            cfg_read(hsr_pkg::REG_IDX_W'(i));
    endtask

    // writes past the last register must leave the real ones alone
    task automatic poke_unmapped();
        for (int i = int'(hsr_pkg::REG_MAX_LEVEL) + 1; i < 2 ** hsr_pkg::REG_IDX_W; i++)
            cfg_write(hsr_pkg::REG_IDX_W'(i), '0, 0);
        for (int i = 0; i <= int'(hsr_pkg::REG_MAX_LEVEL); i++)
            cfg_read(hsr_pkg::REG_IDX_W'(i));
    endtask

    task automatic apply_setting(int k);
        logic [7:0]  a_b;
        logic [7:0]  a_g;
        logic [7:0]  a_r;
        logic [15:0] flr;
        logic [7:0]  lvl;
        a_b = rand_hazy();
        a_g = rand_hazy();
        a_r = rand_hazy();
        lvl = ($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom_range(0, 255));
        flr = 16'($urandom_range(1, 32768));
        unique case (k)
            0: begin
                a_b = '0; a_g = '0; a_r = '0; flr = 16'd1; lvl = '0;
            end
            1: begin
                a_b = '1; a_g = '1; a_r = '1; flr = 16'd32768; lvl = '1;
            end
            2: flr = '1;
            3: begin
                flr = '0; lvl = '1;
            end
            default: ;
        endcase
        load_regs(a_b, a_g, a_r, flr, lvl);
    endtask

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset register values: floor clamp, full and above-one transmission
        send_pixel(pack_pixel(8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0));
        send_pixel(pack_pixel(8'd255, 8'd255, 8'd255, 16'd32768, 16'd32768, 16'd32768));
        send_pixel(pack_pixel(8'd0, 8'd128, 8'd255, 16'd65535, 16'd65535, 16'd65535));
        send_pixel(pack_pixel(8'd255, 8'd0, 8'd17, 16'd3276, 16'd3277, 16'd3278));
        send_pixel(pack_pixel(8'd128, 8'd255, 8'd0, 16'd1, 16'd16384, 16'd40000));
        settle();

        // zero floor, zero max level: everything positive falls back to hazy
        load_regs(8'd0, 8'd128, 8'd255, 16'd0, 8'd0);
        poke_unmapped();
        send_pixel(pack_pixel(8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0));
        send_pixel(pack_pixel(8'd255, 8'd255, 8'd255, 16'd0, 16'd0, 16'd0));
        send_pixel(pack_pixel(8'd1, 8'd127, 8'd254, 16'd1, 16'd2, 16'd32768));
        send_pixel(pack_pixel(8'd200, 8'd128, 8'd255, 16'd32768, 16'd65535, 16'd0));
        settle();

        // bright airlight with dark pixels drives results negative
        load_regs(8'd255, 8'd0, 8'd100, 16'd1, 8'd255);
        poke_unmapped();
        send_pixel(pack_pixel(8'd0, 8'd255, 8'd0, 16'd1000, 16'd1000, 16'd1000));
        send_pixel(pack_pixel(8'd255, 8'd0, 8'd255, 16'd16384, 16'd16384, 16'd16384));
        send_pixel(pack_pixel(8'd254, 8'd1, 8'd99, 16'd32768, 16'd32767, 16'd0));
        send_pixel(pack_pixel(8'd0, 8'd0, 8'd0, 16'd65535, 16'd65535, 16'd65535));
        send_pixel(pack_pixel(8'd100, 8'd50, 8'd101, 16'd1, 16'd1, 16'd1));
        settle();

        for (int k = 0; k < SETTINGS_PER_RUN; k++) begin
            src_idle_pct   = src_idle_by_phase[k / 2];
            sink_stall_pct = sink_stall_by_phase[k / 2];
            apply_setting(k);
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                send_pixel(pack_pixel(rand_hazy(), rand_hazy(), rand_hazy(),
                                      rand_trans(), rand_trans(), rand_trans()));
                if (k % 2 == 0 && n == ITEMS_PER_SETTING / 2)
                    settle();
            end
            settle();
        end

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
